// File: src/cdr_pkg.sv
package cdr_pkg;

    localparam int IDX_W = 10;
    localparam int ANS_CNT_W = 5;
    localparam logic [ANS_CNT_W-1:0] ANSWER_LEN = 5'd16;

    localparam logic [IDX_W-1:0] HDR_LEN = 10'd12;
    localparam logic [IDX_W-1:0] QTAIL_LEN = 10'd4;
    localparam logic [IDX_W-1:0] MIN_QEND = 10'd16;
    localparam logic [IDX_W-1:0] IDX_MAX = 10'd1023;

    localparam logic [7:0] FLAGS_HI = 8'h81;
    localparam logic [7:0] FLAGS_LO = 8'h80;
    localparam logic [7:0] PTR_HI = 8'hC0;
    localparam logic [7:0] PTR_LO = 8'h0C;
    localparam logic [7:0] TYPE_A = 8'h01;
    localparam logic [7:0] CLASS_IN = 8'h01;
    localparam logic [7:0] TTL_LO = 8'h3C;
    localparam logic [7:0] RDLEN_LO = 8'h04;

    typedef struct packed {
        logic [IDX_W-1:0] byte_index;
        logic [IDX_W-1:0] next_label_pos;
        logic [IDX_W-1:0] q_final_idx;
        logic             name_ended;
        logic             count_high_nonzero;
        logic             frame_done;
    } cdr_state_t;

    localparam cdr_state_t STATE_CLEAR = '{
        byte_index:         '0,
        next_label_pos:     HDR_LEN,
        q_final_idx:        '0,
        name_ended:         1'b0,
        count_high_nonzero: 1'b0,
        frame_done:         1'b0
    };

    typedef struct packed {
        logic       emit;
        logic [7:0] data;
        logic       last;
        logic       drop;
        logic       complete;
    } cdr_result_t;

    // answer record byte k of 1..16, following the passed-through question
    function automatic logic [7:0] answer_byte(input logic [ANS_CNT_W-1:0] k,
                                               input logic [31:0] addr);
        logic [7:0] b;
        begin
            case (k)
                5'd1:    b = PTR_HI;
                5'd2:    b = PTR_LO;
                5'd4:    b = TYPE_A;
                5'd6:    b = CLASS_IN;
                5'd10:   b = TTL_LO;
                5'd12:   b = RDLEN_LO;
                5'd13:   b = addr[31:24];
                5'd14:   b = addr[23:16];
                5'd15:   b = addr[15:8];
                5'd16:   b = addr[7:0];
                default: b = 8'h00;
            endcase
            return b;
        end
    endfunction

endpackage

// File: src/captive_dns_responder_top.sv
// DNS A-record responder.
// s_* : request stream, one byte per beat, s_tlast on the final request byte.
// m_* : reply stream, one byte per beat; m_tlast closes the reply frame and
//       m_tuser set on that beat means the reply is to be discarded.
// cfg_* : answer address write, taken whenever cfg_valid is high.
// Each request byte is parsed in the cycle it is accepted and its reply byte
// sits in the output register on the next cycle. Bytes are taken
// one per cycle while the output register drains. The last question byte
// triggers a 17-beat burst (question byte plus 16-byte answer) from the
// output register, holding s_tready low only if that byte carried s_tlast.
// Later request bytes are swallowed without output and never stall.
// When m_tready is low the output register holds its beat and s_tready drops
// unless the frame is already finished.
// Reset clears the parser state, the output valid and the answer address
// (0.0.0.0); the first byte after reset starts a new request.
module captive_dns_responder_top #(
    parameter int MAX_PACKET = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] request_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] response_byte
    output logic        m_tlast,
    output logic        m_tuser,   // [0] drop
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);
    import cdr_pkg::*;

    cdr_state_t  st_reg, st_next;
    cdr_result_t res;

    logic [31:0]          addr_reg;
    logic                 valid_reg, valid_next;
    logic                 burst_reg, burst_next;
    logic [ANS_CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]           byte_reg, byte_next;
    logic                 last_reg, last_next;
    logic                 drop_reg, drop_next;

    logic advance;
    logic burst_more;
    logic slot_free;
    logic accept;

    cdr_step #(
        .MAX_PACKET(MAX_PACKET)
    ) u_step (
        .st           (st_reg),
        .request_byte (s_tdata),
        .request_last (s_tlast),
        .st_next      (st_next),
        .res          (res)
    );

    assign advance    = valid_reg && m_tready;
    assign burst_more = burst_reg && (cnt_reg != ANSWER_LEN);
    assign slot_free  = !valid_reg || (m_tready && !burst_more);
    assign s_tready   = st_reg.frame_done || slot_free;
    assign accept     = s_tvalid && s_tready;
    assign cfg_ready  = 1'b1;

    assign m_tvalid = valid_reg;
    assign m_tdata  = byte_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = drop_reg;

    always_comb
    begin
        valid_next = valid_reg;
        burst_next = burst_reg;
        cnt_next   = cnt_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        drop_next  = drop_reg;
        if (accept && res.emit)
        begin
            valid_next = 1'b1;
            burst_next = res.complete;
            cnt_next   = '0;
            byte_next  = res.data;
            last_next  = res.last;
            drop_next  = res.drop;
        end
        else if (advance)
        begin
            if (burst_more)
            begin
                cnt_next  = cnt_reg + ANS_CNT_W'(1);
                byte_next = answer_byte(cnt_reg + ANS_CNT_W'(1), addr_reg);
                last_next = ((cnt_reg + ANS_CNT_W'(1)) == ANSWER_LEN);
                drop_next = 1'b0;
            end
            else
            begin
                valid_next = 1'b0;
                burst_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= STATE_CLEAR;
            addr_reg  <= '0;
            valid_reg <= 1'b0;
            burst_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            if (accept)
            begin
                st_reg <= st_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                addr_reg <= cfg_data;
            end
            valid_reg <= valid_next;
            burst_reg <= burst_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
        drop_reg <= drop_next;
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= ANSWER_LEN)
        else $error("answer counter out of range");

    a_drop_final: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tlast && !burst_reg))
        else $error("drop beat not final or inside answer burst");

    a_burst_cont: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && burst_more) |=> (m_tvalid && !$stable(cnt_reg)))
        else $error("answer burst broken");

    a_no_take_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && burst_more && !st_reg.frame_done) |-> !s_tready)
        else $error("request taken during answer burst");

endmodule

// File: src/cdr_step.sv
module cdr_step #(
    parameter int MAX_PACKET = 512
) (
    input  cdr_pkg::cdr_state_t  st,
    input  logic [7:0]           request_byte,
    input  logic                 request_last,
    output cdr_pkg::cdr_state_t  st_next,
    output cdr_pkg::cdr_result_t res
);
    import cdr_pkg::*;

    localparam logic [IDX_W-1:0] LIMIT = IDX_W'(MAX_PACKET - 17);

    logic [IDX_W-1:0] i;
    logic [7:0]       ob;
    logic             fail;
    logic             complete;
    logic [IDX_W:0]   np;

    assign i  = st.byte_index;
    assign np = {1'b0, i} + {3'b000, request_byte} + (IDX_W+1)'(1);

    always_comb
    begin
        st_next  = st;
        res      = '0;
        ob       = request_byte;
        fail     = 1'b0;
        complete = 1'b0;
        if (st.frame_done)
        begin
            if (request_last)
            begin
                st_next = STATE_CLEAR;
            end
        end
        else
        begin
            case (i)
                10'd2:  ob = FLAGS_HI;
                10'd3:  ob = FLAGS_LO;
                10'd4:
                begin
                    ob = 8'h00;
                    st_next.count_high_nonzero = (request_byte != 8'h00);
                end
                10'd5:
                begin
                    ob = 8'h01;
                    if (!st.count_high_nonzero && request_byte == 8'h00)
                    begin
                        fail = 1'b1;
                    end
                end
                10'd6:  ob = 8'h00;
                10'd7:  ob = 8'h01;
                10'd8, 10'd9, 10'd10, 10'd11: ob = 8'h00;
                default: ob = request_byte;
            endcase

            // label walk over the first question name
            if (i >= HDR_LEN && !st.name_ended && i == st.next_label_pos)
            begin
                if (request_byte == 8'h00)
                begin
                    st_next.name_ended  = 1'b1;
                    st_next.q_final_idx = i + QTAIL_LEN;
                end
                else if (np[IDX_W])
                begin
                    st_next.next_label_pos = IDX_MAX;
                end
                else
                begin
                    st_next.next_label_pos = np[IDX_W-1:0];
                end
            end

            complete = st.name_ended && (i == st.q_final_idx) && (i >= MIN_QEND);

            if (!fail && !complete && (request_last || i >= LIMIT))
            begin
                fail = 1'b1;
            end

            res.emit = 1'b1;
            if (fail)
            begin
                res.last = 1'b1;
                res.drop = 1'b1;
            end
            else
            begin
                res.data     = ob;
                res.complete = complete;
            end

            if (fail || complete)
            begin
                if (request_last)
                begin
                    st_next = STATE_CLEAR;
                end
                else
                begin
                    st_next.frame_done = 1'b1;
                end
            end
            else
            begin
                st_next.byte_index = i + IDX_W'(1);
            end
        end
    end

endmodule
